// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RDG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RDG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rdg_pkg.sv =====
package rdg_pkg;

   // Derivative width and the widths that follow from it
   localparam int DERIV_BITS = 16;
   localparam int S_W        = DERIV_BITS + 1;   // sum and difference
   localparam int MAG_W      = DERIV_BITS + 1;   // magnitudes, both roots
   localparam int SQ_W       = 2 * MAG_W;        // one square, and the sum of two
   localparam int GAIN_W     = 16;               // Q8.8 register width
   localparam int SCL_A_W    = (DERIV_BITS > GAIN_W) ? DERIV_BITS : GAIN_W;
   localparam int PROD_W     = SCL_A_W + MAG_W;  // gain times root
   localparam int LAPP_W     = GAIN_W + MAG_W;   // scale_square times |s|
   localparam int LAPS_W     = LAPP_W + 1;

   // Square root pipeline: two result bits per stage
   localparam int RAD_NEED   = (SQ_W > PROD_W) ? SQ_W : PROD_W;
   localparam int SQ_RAD_W   = ((RAD_NEED + 3) / 4) * 4;
   localparam int SQ_ROOT_W  = SQ_RAD_W / 2;
   localparam int SQ_STAGES  = SQ_RAD_W / 4;
   localparam int SQ_REM_W   = SQ_ROOT_W + 4;

   // Result format
   localparam int OUT_W       = 24;
   localparam int FRAC_SHIFT  = 12;
   localparam logic [OUT_W-1:0] RIDGE_MAX = {OUT_W{1'b1}};
   localparam logic [OUT_W-1:0] LAP_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] LAP_MIN   = {1'b1, {(OUT_W-1){1'b0}}};
   localparam longint unsigned LAP_MIN_MAG = 64'd1 << (OUT_W - 1);
   localparam longint unsigned FRAC_ROUND  = (64'd1 << FRAC_SHIFT) - 64'd1;

   // Stream and register port widths
   localparam int REQ_DATA_W = ((3 * DERIV_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * OUT_W + 7) / 8) * 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RIDGE_GAIN   = 2'd0,
      CSR_SCALE_SQUARE = 2'd1,
      CSR_BLOB_ENABLE  = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [GAIN_W-1:0] ridge_gain;
      logic [GAIN_W-1:0] scale_square;
      logic              blob_enable;
   } cfg_type;

   // Per-item payload that rides beside the root pipelines
   typedef struct packed {
      logic [DERIV_BITS-1:0] s_pos;   // s when s >= 0, else zero
      logic [OUT_W-1:0]      lap;     // finished Laplacian result
   } side_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_ROOT_W-1:0] root;
   } sq_type;

   // One restoring square-root step: bring down two radicand bits
   function automatic sq_type sq_step(sq_type cur, logic [1:0] pair);
      logic [SQ_REM_W-1:0] rem_sh;
      logic [SQ_REM_W-1:0] trial;
      sq_type              nxt;
      rem_sh = {cur.rem[SQ_REM_W-3:0], pair};
      trial  = {{(SQ_REM_W-SQ_ROOT_W-2){1'b0}}, cur.root, 2'b01};
      if (rem_sh >= trial) begin
         nxt.rem  = rem_sh - trial;
         nxt.root = {cur.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = rem_sh;
         nxt.root = {cur.root[SQ_ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/rdg_csr.sv =====
module rdg_csr
   import rdg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; unknown indexes leave everything as is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RIDGE_GAIN:   cfg_in.ridge_gain   = csr_data[GAIN_W-1:0];
            CSR_SCALE_SQUARE: cfg_in.scale_square = csr_data[GAIN_W-1:0];
            CSR_BLOB_ENABLE:  cfg_in.blob_enable  = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ridge_gain   <= GAIN_W'(256);
         cfg_ff.scale_square <= GAIN_W'(256);
         cfg_ff.blob_enable  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/rdg_front.sv =====
module rdg_front
   import rdg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   input  logic [DERIV_BITS-1:0] deriv_xx,
   input  logic [DERIV_BITS-1:0] deriv_yy,
   input  logic [DERIV_BITS-1:0] deriv_xy,
   output logic                  out_valid,
   output logic [SQ_RAD_W-1:0]   out_rad,
   output side_type              out_side
);

   // Stage 1: sum, difference, magnitudes
   logic [2:0]       valid_ff;
   logic [S_W-1:0]   s_ff;
   logic [MAG_W-1:0] ad_ff;
   logic [MAG_W-1:0] axy2_ff;
   logic [S_W-1:0]   s_in;
   logic [S_W-1:0]   d_in;
   logic [S_W-1:0]   xy_ext;
   logic [MAG_W-1:0] ad_in;
   logic [MAG_W-1:0] axy_mag;
   logic [MAG_W-1:0] axy2_in;

   always_comb begin
      s_in    = {deriv_xx[DERIV_BITS-1], deriv_xx} + {deriv_yy[DERIV_BITS-1], deriv_yy};
      d_in    = {deriv_xx[DERIV_BITS-1], deriv_xx} - {deriv_yy[DERIV_BITS-1], deriv_yy};
      xy_ext  = {deriv_xy[DERIV_BITS-1], deriv_xy};
      ad_in   = d_in[S_W-1] ? (S_W'(0) - d_in) : d_in;
      axy_mag = xy_ext[S_W-1] ? (S_W'(0) - xy_ext) : xy_ext;
      axy2_in = {axy_mag[MAG_W-2:0], 1'b0};
   end

   // Stage 2: the two squares and the Laplacian product
   logic [SQ_W-1:0]       sqd_ff;
   logic [SQ_W-1:0]       sqx_ff;
   logic [LAPP_W-1:0]     lapp_ff;
   logic                  neg_ff;
   logic [DERIV_BITS-1:0] spos_ff;
   logic                  neg_in;
   logic [MAG_W-1:0]      smag_in;
   logic [DERIV_BITS-1:0] spos_in;

   always_comb begin
      neg_in  = s_ff[S_W-1];
      smag_in = neg_in ? (S_W'(0) - s_ff) : s_ff;
      spos_in = neg_in ? '0 : s_ff[DERIV_BITS-1:0];
   end

   // Stage 3: radicand and the finished Laplacian result
   logic [SQ_RAD_W-1:0]   rad_ff;
   side_type              side_ff;
   logic [SQ_RAD_W-1:0]   rad_in;
   logic [LAPS_W-1:0]     lap_sum;
   logic [LAPS_W-1:0]     lap_q;
   longint unsigned       lap_mag;
   logic [OUT_W-1:0]      lap_in;

   always_comb begin
      rad_in  = SQ_RAD_W'(sqd_ff) + SQ_RAD_W'(sqx_ff);
      // Negative sums round toward minus infinity: add the fraction mask first
      lap_sum = LAPS_W'(lapp_ff) + (neg_ff ? LAPS_W'(FRAC_ROUND) : LAPS_W'(0));
      lap_q   = lap_sum >> FRAC_SHIFT;
      lap_mag = 64'(lap_q);
      if (!cfg.blob_enable) begin
         lap_in = '0;
      end else if (!neg_ff) begin
         lap_in = (lap_mag > 64'(LAP_MAX)) ? LAP_MAX : lap_mag[OUT_W-1:0];
      end else begin
         lap_in = (lap_mag > LAP_MIN_MAG) ? LAP_MIN : (OUT_W'(0) - lap_mag[OUT_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
      if (en) begin
         s_ff          <= s_in;
         ad_ff         <= ad_in;
         axy2_ff       <= axy2_in;
         sqd_ff        <= SQ_W'(ad_ff) * SQ_W'(ad_ff);
         sqx_ff        <= SQ_W'(axy2_ff) * SQ_W'(axy2_ff);
         lapp_ff       <= LAPP_W'(cfg.scale_square) * LAPP_W'(smag_in);
         neg_ff        <= neg_in;
         spos_ff       <= spos_in;
         rad_ff        <= rad_in;
         side_ff.s_pos <= spos_ff;
         side_ff.lap   <= lap_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/rdg_sqrt.sv =====
module rdg_sqrt
   import rdg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [SQ_RAD_W-1:0] in_rad,
   input  side_type            in_side,
   output logic                out_valid,
   output logic [MAG_W-1:0]    out_root,
   output side_type            out_side
);

   logic [SQ_STAGES-1:0] valid_ff;
   logic [SQ_RAD_W-1:0]  rad_ff  [SQ_STAGES];
   sq_type               acc_ff  [SQ_STAGES];
   side_type             side_ff [SQ_STAGES];

   // Each stage settles two root bits from the top four radicand bits
   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
      logic                prev_valid;
      logic [SQ_RAD_W-1:0] prev_rad;
      sq_type              prev_acc;
      side_type            prev_side;
      sq_type              mid;
      sq_type              acc_in;
      logic [SQ_RAD_W-1:0] rad_in;

      if (g == 0) begin : g_head
         assign prev_valid = in_valid;
         assign prev_rad   = in_rad;
         assign prev_acc   = '0;
         assign prev_side  = in_side;
      end else begin : g_tail
         assign prev_valid = valid_ff[g-1];
         assign prev_rad   = rad_ff[g-1];
         assign prev_acc   = acc_ff[g-1];
         assign prev_side  = side_ff[g-1];
      end

      always_comb begin
         mid    = sq_step(prev_acc, prev_rad[SQ_RAD_W-1:SQ_RAD_W-2]);
         acc_in = sq_step(mid, prev_rad[SQ_RAD_W-3:SQ_RAD_W-4]);
         rad_in = {prev_rad[SQ_RAD_W-5:0], 4'b0000};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= prev_valid;
         end
         if (en) begin
            rad_ff[g]  <= rad_in;
            acc_ff[g]  <= acc_in;
            side_ff[g] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[SQ_STAGES-1];
   assign out_root  = acc_ff[SQ_STAGES-1].root[MAG_W-1:0];
   assign out_side  = side_ff[SQ_STAGES-1];

endmodule

// ===== rtl/rdg_scale.sv =====
module rdg_scale
   import rdg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [SCL_A_W-1:0] in_gain,
   input  logic [MAG_W-1:0]   in_value,
   input  side_type           in_side,
   output logic               out_valid,
   output logic [PROD_W-1:0]  out_prod,
   output side_type           out_side
);

   logic              valid_ff;
   logic [PROD_W-1:0] prod_ff;
   side_type          side_ff;

   // Register the product; side payload moves along with it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         prod_ff <= PROD_W'(in_gain) * PROD_W'(in_value);
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/ridge_strength_pixel.sv =====
// Scale-normalized ridge strength, one pixel per transfer. Each request carries
// the pixel's second derivatives xx, yy, xy (signed Q3.12); each response gives
// ridge_response = ridge_gain * sqrt(s * sqrt(d^2 + 4*xy^2)) (zero when s < 0)
// and laplacian_response = scale_square * s (zero unless blob_enable), both in
// units of 1/256, truncated and saturated, with s = xx+yy and d = xx-yy. The
// pipeline takes one pixel per clock unless held and passes it through three
// front stages (sum/difference, squares, radicand), two nine-stage square-root
// pipelines of two bits per stage, two multiply stages and the output register.
// The whole pipeline advances together and holds while a finished result waits
// on rsp_tready. The user must write the registers through the csr port only
// while no pixel is in flight, not enforced by the block; it is always ready.
module ridge_strength_pixel
   import rdg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: deriv_xx, deriv_yy, deriv_xy (lowest bits first)
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: ridge_response, laplacian_response (lowest bits first)
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;
   logic    en;

   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    ridge_ff;
   logic [OUT_W-1:0]    lap_ff;
   logic [OUT_W-1:0]    ridge_in;

   logic                fr_valid;
   logic [SQ_RAD_W-1:0] fr_rad;
   side_type            fr_side;
   logic                m_valid;
   logic [MAG_W-1:0]    m_root;
   side_type            m_side;
   logic                sm_valid;
   logic [PROD_W-1:0]   sm_prod;
   side_type            sm_side;
   logic                r_valid;
   logic [MAG_W-1:0]    r_root;
   side_type            r_side;
   logic                g_valid;
   logic [PROD_W-1:0]   g_prod;
   side_type            g_side;
   longint unsigned     ridge_q;

   // Advance everything unless a finished result is held
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   rdg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rdg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .deriv_xx  (req_tdata[DERIV_BITS-1:0]),
      .deriv_yy  (req_tdata[2*DERIV_BITS-1:DERIV_BITS]),
      .deriv_xy  (req_tdata[3*DERIV_BITS-1:2*DERIV_BITS]),
      .out_valid (fr_valid),
      .out_rad   (fr_rad),
      .out_side  (fr_side)
   );

   // m = sqrt(d^2 + (2xy)^2)
   rdg_sqrt u_sqrt_mag (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_side   (fr_side),
      .out_valid (m_valid),
      .out_root  (m_root),
      .out_side  (m_side)
   );

   // s * m; s is zero for a negative Laplacian, which zeroes the ridge result
   rdg_scale u_scale_sm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid),
      .in_gain   (SCL_A_W'(m_side.s_pos)),
      .in_value  (m_root),
      .in_side   (m_side),
      .out_valid (sm_valid),
      .out_prod  (sm_prod),
      .out_side  (sm_side)
   );

   // r = sqrt(s * m)
   rdg_sqrt u_sqrt_ridge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sm_valid),
      .in_rad    (SQ_RAD_W'(sm_prod)),
      .in_side   (sm_side),
      .out_valid (r_valid),
      .out_root  (r_root),
      .out_side  (r_side)
   );

   // ridge_gain * r
   rdg_scale u_scale_gain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid),
      .in_gain   (SCL_A_W'(cfg.ridge_gain)),
      .in_value  (r_root),
      .in_side   (r_side),
      .out_valid (g_valid),
      .out_prod  (g_prod),
      .out_side  (g_side)
   );

   // Drop the fraction and saturate
   always_comb begin
      ridge_q  = 64'(g_prod >> FRAC_SHIFT);
      ridge_in = (ridge_q > 64'(RIDGE_MAX)) ? RIDGE_MAX : ridge_q[OUT_W-1:0];
   end

   // Output register: hold the result until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= g_valid;
      end
      if (en) begin
         ridge_ff <= ridge_in;
         lap_ff   <= g_side.lap;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({lap_ff, ridge_ff});

endmodule

// ===== rtl/rdg_checker.sv =====
`include "assert_macros.svh"

module rdg_checker
   import rdg_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A held response keeps its data
   `RDG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // An empty output register never blocks requests
   `RDG_ASSERT_SAME(a_req_ready, clock, reset, !rsp_tvalid, req_tready, "request stalled with empty output")

   // A negative Laplacian means s < 0, so the ridge result is zero
   `RDG_ASSERT_SAME(a_neg_lap_ridge, clock, reset, rsp_tvalid && rsp_tdata[2*OUT_W-1], rsp_tdata[OUT_W-1:0] == '0, "ridge nonzero with negative Laplacian")

   // Nothing comes out right after reset
   `RDG_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid, "response valid right after reset")

endmodule

bind ridge_strength_pixel rdg_checker u_rdg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/tb.sv =====
module tb;
   import rdg_pkg::*;

   localparam int           CLK_HALF      = 10;
   localparam int           RESET_CYCLES  = 9;
   localparam int           PHASE_ITEMS   = 150;
   localparam int           RANDOM_PHASES = 6;
   localparam int           HOLD_CYCLES   = 200;
   localparam int           DRAIN_CYCLES  = 40;
   localparam int unsigned  CYCLE_LIMIT   = 200000;

   // Index that maps to no register; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 2'd3;

   typedef struct packed {
      logic [OUT_W-1:0] ridge;
      logic [OUT_W-1:0] lap;
   } response_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Register values as the block should hold them
   cfg_type cfg_now = '{ridge_gain: 16'd256, scale_square: 16'd256, blob_enable: 1'b0};

   logic [REQ_DATA_W-1:0] pixel_backlog[$];
   response_type          pending_responses[$];
   int                    pixels_issued = 0;
   int                    responses_seen = 0;
   int                    error_count = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   bit                    hold_on = 1'b0;
   int                    hold_count = 0;
   int unsigned           cycle_count = 0;

   ridge_strength_pixel u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Integer square root, truncated; radicands stay well below 2^40
   function automatic longint floor_sqrt(input longint v);
      longint root_v;
      longint cand;
      int     b;
      root_v = 0;
      for (b = 20; b >= 0; b--) begin
         cand = root_v | (longint'(1) << b);
         if (cand * cand <= v) begin
            root_v = cand;
         end
      end
      return root_v;
   endfunction

   // Ridge strength and Laplacian of one pixel under the current registers
   function automatic response_type predict_pixel_response(input logic [REQ_DATA_W-1:0] pix);
      longint       xx, yy, xy;
      longint       sum_v, dif_v;
      longint       mag_root, ridge_root, ridge_v, lap_v, prod;
      response_type res;
      xx = longint'($signed(pix[DERIV_BITS-1:0]));
      yy = longint'($signed(pix[2*DERIV_BITS-1:DERIV_BITS]));
      xy = longint'($signed(pix[3*DERIV_BITS-1:2*DERIV_BITS]));
      sum_v = xx + yy;
      dif_v = xx - yy;
      ridge_v = 0;
      lap_v = 0;
      // Ridge only where the Laplacian is not negative
      if (sum_v >= 0) begin
         mag_root = floor_sqrt(dif_v * dif_v + 4 * xy * xy);
         ridge_root = floor_sqrt(sum_v * mag_root);
         ridge_v = (longint'(cfg_now.ridge_gain) * ridge_root) >>> FRAC_SHIFT;
         if (ridge_v > longint'(RIDGE_MAX)) begin
            ridge_v = longint'(RIDGE_MAX);
         end
      end
      // Laplacian floors toward minus infinity, then saturates
      if (cfg_now.blob_enable) begin
         prod = longint'(cfg_now.scale_square) * ((sum_v < 0) ? -sum_v : sum_v);
         if (sum_v < 0) begin
            lap_v = -((prod + longint'(FRAC_ROUND)) >>> FRAC_SHIFT);
         end else begin
            lap_v = prod >>> FRAC_SHIFT;
         end
         if (lap_v > longint'(LAP_MAX)) begin
            lap_v = longint'(LAP_MAX);
         end
         if (lap_v < -longint'(LAP_MIN_MAG)) begin
            lap_v = -longint'(LAP_MIN_MAG);
         end
      end
      res.ridge = ridge_v[OUT_W-1:0];
      res.lap = lap_v[OUT_W-1:0];
      return res;
   endfunction

   // Mix of full-range, corner and near-zero derivatives
   function automatic logic [DERIV_BITS-1:0] rand_deriv();
      case ($urandom_range(0, 3))
         0, 1: return DERIV_BITS'($urandom);
         2: begin
            case ($urandom_range(0, 6))
               0: return 16'h8000;
               1: return 16'h8001;
               2: return 16'hFFFF;
               3: return 16'h0000;
               4: return 16'h0001;
               5: return 16'h7FFE;
               default: return 16'h7FFF;
            endcase
         end
         default: return DERIV_BITS'($urandom_range(0, 64)) - 16'd32;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                  input logic [OUT_W-1:0] want);
      $display("MISMATCH %s: got %h expected %h (response %0d)", what, got, want,
               responses_seen);
      error_count++;
   endtask

   task automatic queue_pixel(input logic [DERIV_BITS-1:0] xx, input logic [DERIV_BITS-1:0] yy,
                              input logic [DERIV_BITS-1:0] xy);
      pixel_backlog.insert(pixel_backlog.size(), {xy, yy, xx});
      pixels_issued++;
   endtask

   // Hold the write until the port takes it, then track the new value
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_RIDGE_GAIN:   cfg_now.ridge_gain = val[GAIN_W-1:0];
         CSR_SCALE_SQUARE: cfg_now.scale_square = val[GAIN_W-1:0];
         CSR_BLOB_ENABLE:  cfg_now.blob_enable = val[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (responses_seen != pixels_issued) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 9;
            recv_idle_pct = 82;
         end
         1: begin
            send_idle_pct = 82;
            recv_idle_pct = 9;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   // Request driver: present the next pixel once the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_responses.insert(pending_responses.size(),
                                     predict_pixel_response(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tdata <= pixel_backlog.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side: one long hold-off when asked, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_on && hold_count < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Compare each response transfer with the oldest prediction
   always @(posedge clock) begin : response_check
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[OUT_W-1:0], '0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata[OUT_W-1:0] !== want.ridge) begin
               report_mismatch("ridge_response", rsp_tdata[OUT_W-1:0], want.ridge);
            end
            if (rsp_tdata[2*OUT_W-1:OUT_W] !== want.lap) begin
               report_mismatch("laplacian_response", rsp_tdata[2*OUT_W-1:OUT_W], want.lap);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int phase;
      int n;
      logic [CSR_DATA_W-1:0] gain_val, square_val, blob_val;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels under the reset register values
      set_idling(0);
      queue_pixel(16'h0000, 16'h0000, 16'h0000);
      queue_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF);
      queue_pixel(16'h8000, 16'h8000, 16'h8000);
      queue_pixel(16'h8000, 16'h7FFF, 16'h0000);   // sum just below zero
      queue_pixel(16'h7FFF, 16'h8000, 16'h8000);   // negative sum, widest difference
      queue_pixel(16'h7FFF, 16'h8001, 16'h8000);   // zero sum, widest difference
      queue_pixel(16'h0001, 16'hFFFF, 16'h0000);
      queue_pixel(16'h7FFF, 16'h0000, 16'h8000);
      queue_pixel(16'h0000, 16'h0000, 16'h7FFF);
      queue_pixel(16'h0000, 16'h0000, 16'h8000);
      queue_pixel(16'h1000, 16'h1000, 16'h0000);   // isotropic: inner root is zero
      queue_pixel(16'h1000, 16'hF000, 16'h0000);
      queue_pixel(16'h2000, 16'h1000, 16'h0800);
      queue_pixel(16'hFFFF, 16'h0000, 16'h0000);
      queue_pixel(16'h0001, 16'h0000, 16'h0001);
      queue_pixel(16'h7FFF, 16'h7FFF, 16'h0000);
      queue_pixel(16'hFC00, 16'h0100, 16'h1234);
      wait_drained();

      // Random phases, each under its own register setting
      for (phase = 1; phase <= RANDOM_PHASES; phase++) begin
         case (phase)
            1: begin
               gain_val = 16'hFFFF;
               square_val = 16'hFFFF;
               blob_val = 16'hFFFF;
            end
            2: begin
               gain_val = 16'h0000;
               square_val = 16'h0000;
               blob_val = 16'h0001;
            end
            3: begin
               gain_val = 16'h0001;
               square_val = 16'h0001;
               blob_val = 16'hFFFE;
            end
            4: begin
               gain_val = CSR_DATA_W'($urandom);
               square_val = CSR_DATA_W'($urandom);
               blob_val = 16'h0001;
            end
            5: begin
               gain_val = CSR_DATA_W'($urandom);
               square_val = 16'h8000;
               blob_val = 16'h0000;
            end
            default: begin
               gain_val = 16'h0100;
               square_val = CSR_DATA_W'($urandom);
               blob_val = 16'h0001;
            end
         endcase
         write_reg(CSR_RIDGE_GAIN, gain_val);
         write_reg(CSR_SCALE_SQUARE, square_val);
         write_reg(CSR_BLOB_ENABLE, blob_val);
         if (phase == 2) begin
            write_reg(CSR_IDX_UNUSED, CSR_DATA_W'($urandom));
         end
         set_idling((phase - 1) % 3);
         // Last phase: stall the response side while requests keep coming
         if (phase == RANDOM_PHASES) begin
            hold_on = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            queue_pixel(rand_deriv(), rand_deriv(), rand_deriv());
         end
         wait_drained();
      end

      // Let any stray response show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_responses.size() != 0) begin
         report_mismatch("responses never returned", '0, OUT_W'(pending_responses.size()));
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rdg_pkg.sv
rtl/rdg_csr.sv
rtl/rdg_front.sv
rtl/rdg_sqrt.sv
rtl/rdg_scale.sv
rtl/ridge_strength_pixel.sv
rtl/rdg_checker.sv
sim/tb.sv
